[design/u8v_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
package u8v_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned TAIL_W = 2;

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_FORBIDDEN = 3'd1,
    ST_OVERLONG  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_LONG      = 3'd4
  } status_t;

  typedef struct packed {
    status_t             err;
    logic [TAIL_W-1:0]   tail;
    logic [CP_W-1:0]     cp;
  } u8v_step_t;

endpackage

[design/u8v_byte_if.sv]
// Input channel: one string byte per word with an end-of-string flag.
interface u8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

[design/u8v_status_if.sv]
// Output channel: one validation status word per string.
interface u8v_status_if import u8v_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

[design/u8v_decode.sv]
// Per-byte UTF-8 decode step: error code and next tail count and codepoint.
module u8v_decode import u8v_pkg::*; (
  input  logic [7:0]        byte_in,
  input  logic [TAIL_W-1:0] tail,
  input  logic [CP_W-1:0]   cp,
  output u8v_step_t         step
);

  logic [TAIL_W-1:0] tail_dec;
  logic [CP_W-1:0]   cp_or;
  logic [CP_W-1:0]   cp_cont;

  assign tail_dec = tail - TAIL_W'(1);

  // A pending tail is at most two after one decrement, so the shift is 0, 6 or 12.
  always_comb begin
    case (tail_dec)
      2'd0:    cp_or = {{(CP_W-6){1'b0}}, byte_in[5:0]};
      2'd1:    cp_or = {{(CP_W-12){1'b0}}, byte_in[5:0], 6'b0};
      default: cp_or = {{(CP_W-18){1'b0}}, byte_in[5:0], 12'b0};
    endcase
  end

  assign cp_cont = cp | cp_or;

  always_comb begin
    step.err  = ST_VALID;
    step.tail = tail;
    step.cp   = cp;
    if (!byte_in[7]) begin
      if (tail != '0) begin
        step.err = ST_SHORT;
      end else begin
        step.cp = {{(CP_W-8){1'b0}}, byte_in};
      end
    end else if (byte_in[7:6] == 2'b10) begin
      if (tail == '0) begin
        step.err = ST_LONG;
      end else begin
        step.tail = tail_dec;
        step.cp   = cp_cont;
        if (cp_cont == '0) step.err = ST_OVERLONG;
      end
    end else if (byte_in[7:5] == 3'b110) begin
      if (tail != '0) begin
        step.err = ST_SHORT;
      end else begin
        step.tail = TAIL_W'(1);
        step.cp   = {{(CP_W-11){1'b0}}, byte_in[4:0], 6'b0};
        if (byte_in[4:0] == 5'd0) step.err = ST_OVERLONG;
      end
    end else if (byte_in[7:4] == 4'b1110) begin
      if (tail != '0) begin
        step.err = ST_SHORT;
      end else begin
        step.tail = TAIL_W'(2);
        step.cp   = {{(CP_W-16){1'b0}}, byte_in[3:0], 12'b0};
      end
    end else if (byte_in[7:3] == 5'b11110) begin
      if (tail != '0) begin
        step.err = ST_SHORT;
      end else begin
        step.tail = TAIL_W'(3);
        step.cp   = {byte_in[2:0], 18'b0};
        // Leads F5 to F7 put the value above the last Unicode codepoint.
        if (byte_in[2:0] > 3'd4) step.err = ST_FORBIDDEN;
      end
    end else begin
      step.err = ST_FORBIDDEN;
    end
  end

endmodule

[design/utf8_stream_validator.sv]
// UTF-8 stream validator: one status word per string, one byte word per cycle.
// A final byte is held in the input register, and its status is then presented from the result register.
// Throughput: one byte word per cycle; the decode step and the state update sit
// between the input register and the result register.
// The input stalls only while a final byte waits behind a status not yet taken.
// Reset (rst, synchronous) clears the tail count, codepoint, held error and valids.
module utf8_stream_validator import u8v_pkg::*; (
  input logic         clk,
  input logic         rst,
  u8v_byte_if.sink    data,
  u8v_status_if.source result
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic [TAIL_W-1:0] tail;
  logic [CP_W-1:0]   partial;
  status_t           first_err;
  u8v_step_t         step;
  status_t           err_now;
  status_t           final_status;
  logic              advance;
  logic              finish;

  u8v_decode u_decode (
    .byte_in (s1_byte),
    .tail    (tail),
    .cp      (partial),
    .step    (step)
  );

  // Bytes that are not final never produce a word, so they always move on.
  assign advance    = s1_valid && (!s1_last || !result.valid || result.ready);
  assign finish     = advance && s1_last;
  assign data.ready = !s1_valid || advance;

  assign err_now = (first_err != ST_VALID) ? first_err : step.err;

  always_comb begin
    final_status = err_now;
    if (err_now == ST_VALID && step.tail != '0) final_status = ST_SHORT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      tail         <= '0;
      partial      <= '0;
      first_err    <= ST_VALID;
      result.valid <= 1'b0;
    end else begin
      if (data.ready) s1_valid <= data.valid;
      if (finish) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (finish) begin
        tail      <= '0;
        partial   <= '0;
        first_err <= ST_VALID;
      end else if (advance && first_err == ST_VALID) begin
        tail      <= step.tail;
        partial   <= step.cp;
        first_err <= step.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      s1_byte <= data.byte_in;
      s1_last <= data.last_byte;
    end
    if (finish) result.status <= final_status;
  end

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_valid && s1_last))
    else $error("status word appeared without a final byte");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    finish |=> (tail == '0 && partial == '0 && first_err == ST_VALID))
    else $error("string state not cleared after the final byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_err != ST_VALID && !finish) |=> first_err == $past(first_err))
    else $error("held error changed before the end of the string");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !data.ready |-> (s1_valid && s1_last && result.valid && !result.ready))
    else $error("input stalled without a blocked final byte");

endmodule

[bench/utf8_stream_validator_test.sv]
// Self-checking testbench for the UTF-8 stream validator with randomized flow control.
`timescale 1ns / 100ps

module utf8_stream_validator_test import u8v_pkg::*; ();

  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AT_WORD = 20;
  localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct {
    logic [7:0] b;
    logic       is_last;
    bit         drain;
  } byte_word_t;

  logic clk;
  logic rst;

  u8v_byte_if   byte_ch();
  u8v_status_if status_ch();

  utf8_stream_validator dut (
    .clk    (clk),
    .rst    (rst),
    .data   (byte_ch),
    .result (status_ch)
  );

  byte_word_t byte_q[$];
  status_t    want_status_q[$];
  int         errors;

  // Decoder state of the string in progress.
  logic [TAIL_W-1:0] tail_left;
  logic [CP_W-1:0]   cp_bits;
  status_t           held_err;

  function automatic status_t decode_byte(input logic [7:0] c);
    if (!c[7]) begin
      if (tail_left != 0) return ST_SHORT;
      cp_bits = {13'd0, c};
      return ST_VALID;
    end
    if (c[7:6] == 2'b10) begin
      if (tail_left == 0) return ST_LONG;
      tail_left = tail_left - 1'b1;
      cp_bits = cp_bits | (CP_W'(c[5:0]) << (6 * tail_left));
      return (cp_bits == 0) ? ST_OVERLONG : ST_VALID;
    end
    if (c[7:5] == 3'b110) begin
      if (tail_left != 0) return ST_SHORT;
      tail_left = 2'd1;
      cp_bits = CP_W'(c[4:0]) << 6;
      return (cp_bits == 0) ? ST_OVERLONG : ST_VALID;
    end
    if (c[7:4] == 4'b1110) begin
      if (tail_left != 0) return ST_SHORT;
      tail_left = 2'd2;
      cp_bits = CP_W'(c[3:0]) << 12;
      return ST_VALID;
    end
    if (c[7:3] == 5'b11110) begin
      if (tail_left != 0) return ST_SHORT;
      tail_left = 2'd3;
      cp_bits = CP_W'(c[2:0]) << 18;
      return (cp_bits > CP_LIMIT) ? ST_FORBIDDEN : ST_VALID;
    end
    return ST_FORBIDDEN;
  endfunction

  // Once an error is held, the rest of the string is ignored until its final byte.
  task automatic take_word(input logic [7:0] b, input logic is_last);
    status_t st;
    if (held_err == ST_VALID) held_err = decode_byte(b);
    if (is_last) begin
      st = held_err;
      if (st == ST_VALID && tail_left != 0) st = ST_SHORT;
      want_status_q.push_back(st);
      tail_left = '0;
      cp_bits   = '0;
      held_err  = ST_VALID;
    end
  endtask

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // Mostly zero, sometimes a short gap, rarely a long pause; calm stretches have none.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_string(input byte_seq_t s, input bit drain);
    foreach (s[i])
      byte_q.push_back('{b: s[i], is_last: (i == s.size() - 1), drain: (drain && i == 0)});
  endtask

  // Mostly well-formed text with random content, some broken strings and some noise.
  task automatic gen_string(output byte_seq_t s);
    int kind;
    int n;
    logic [7:0] lead;
    s = {};
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 5);
      repeat (n) s.push_back(rand_byte(0, 255));
      return;
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(1, 4))
        1: s.push_back(rand_byte(0, 8'h7F));
        2: begin
          s.push_back(rand_byte(8'hC2, 8'hDF));
          s.push_back(rand_byte(8'h80, 8'hBF));
        end
        3: begin
          lead = rand_byte(8'hE0, 8'hEF);
          s.push_back(lead);
          s.push_back((lead == 8'hE0) ? rand_byte(8'hA0, 8'hBF) : rand_byte(8'h80, 8'hBF));
          s.push_back(rand_byte(8'h80, 8'hBF));
        end
        default: begin
          lead = rand_byte(8'hF0, 8'hF4);
          s.push_back(lead);
          if (lead == 8'hF0)      s.push_back(rand_byte(8'h90, 8'hBF));
          else if (lead == 8'hF4) s.push_back(rand_byte(8'h80, 8'h8F));
          else                    s.push_back(rand_byte(8'h80, 8'hBF));
          s.push_back(rand_byte(8'h80, 8'hBF));
          s.push_back(rand_byte(8'h80, 8'hBF));
        end
      endcase
    end
    if (kind < 30) begin
      case ($urandom_range(0, 3))
        0: if (s.size() > 1) s.delete($urandom_range(0, s.size() - 1));
        1: s.insert($urandom_range(0, s.size()), rand_byte(8'h80, 8'hBF));
        2: s.insert($urandom_range(0, s.size()), rand_byte(8'hC0, 8'hFF));
        default: s.push_back(rand_byte(8'hC2, 8'hF4));
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.byte_in   = 8'h00;
    byte_ch.last_byte = 1'b0;
    status_ch.ready   = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: presents words from byte_q; a drain-marked word waits for all statuses.
  int tx_gap;
  int tx_calm;
  byte_word_t tx_word;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.byte_in   <= 8'h00;
      byte_ch.last_byte <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) tx_gap = pick_gap(tx_calm);
      if (byte_ch.valid && !byte_ch.ready) begin
        // Hold the word until the block takes it.
      end else if (tx_gap > 0) begin
        tx_gap--;
        byte_ch.valid <= 1'b0;
      end else if (byte_q.size() != 0 &&
                   !(byte_q[0].drain && (byte_ch.valid || want_status_q.size() != 0))) begin
        tx_word = byte_q.pop_front();
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= tx_word.b;
        byte_ch.last_byte <= tx_word.is_last;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold that backs the block up.
  int rx_stall;
  int rx_calm;
  int rx_hold;
  int rx_taken;

  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
      rx_stall = 0;
      rx_calm  = 0;
      rx_hold  = 0;
      rx_taken = 0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        rx_taken++;
        if (rx_taken == HOLD_AT_WORD) rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        status_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // Monitor: predicts on every accepted byte word and checks every status word.
  status_t want;

  always @(posedge clk) begin
    if (rst) begin
      tail_left = '0;
      cp_bits   = '0;
      held_err  = ST_VALID;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        if (want_status_q.size() == 0) begin
          errors++;
          $display("%0t: status %0d arrived with no string pending", $time, status_ch.status);
        end else begin
          want = want_status_q.pop_front();
          if (status_ch.status !== want) begin
            errors++;
            $display("%0t: wrong status, expected %0d (%s) got %0d",
                     $time, want, want.name(), status_ch.status);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) take_word(byte_ch.byte_in, byte_ch.last_byte);
    end
  end

  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((byte_ch.valid && byte_ch.ready) || (status_ch.valid && status_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("utf8_stream_validator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    byte_seq_t s;
    int total;
    int next_drain;
    errors = 0;

    // Directed strings: extremes, each error kind, and the cases left unflagged.
    add_string('{8'h00}, 1'b0);
    add_string('{8'h7F}, 1'b0);
    add_string('{8'hC2, 8'h80}, 1'b0);
    add_string('{8'hC0, 8'h80}, 1'b0);
    add_string('{8'hE0, 8'h80}, 1'b0);
    add_string('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
    add_string('{8'hC1, 8'hBF}, 1'b0);
    add_string('{8'hED, 8'hA0, 8'h80}, 1'b0);
    add_string('{8'hF5}, 1'b0);
    add_string('{8'hFF, 8'h41}, 1'b0);
    add_string('{8'h80}, 1'b0);
    add_string('{8'hC3, 8'h41}, 1'b0);
    add_string('{8'hE2, 8'h82}, 1'b0);

    total = 0;
    next_drain = 0;
    while (total < RANDOM_BYTES) begin
      gen_string(s);
      add_string(s, total >= next_drain);
      if (total >= next_drain) next_drain += 150;
      total += s.size();
    end

    @(negedge clk);
    while (rst || byte_q.size() != 0 || byte_ch.valid || want_status_q.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("utf8_stream_validator: match");
    else
      $display("utf8_stream_validator: mismatch");
    $finish;
  end

endmodule

[files.f]
design/u8v_pkg.sv
design/u8v_byte_if.sv
design/u8v_status_if.sv
design/u8v_decode.sv
design/utf8_stream_validator.sv
bench/utf8_stream_validator_test.sv
